// ----- sv/ptarl_pkg.sv -----
// Shared types, widths, register codes and reset values for the alarm rate limiter.
// No dependencies; every other file of the block refers to it by scoped names.
package ptarl_pkg;

	localparam int TOPIC_COUNT_DEF          = 64;
	localparam int CREDIT_FRACTION_BITS_DEF = 16;

	localparam int TOPIC_W       = 6;
	localparam int TOPIC_SPAN    = 1 << TOPIC_W;
	localparam int TOPIC_TBL_W   = 12;
	localparam int TIME_W        = 48;
	localparam int CREDIT_W      = 32;
	localparam int INTERVAL_W    = 32;
	localparam int PERIOD_W      = 32;
	localparam int INIT_CREDIT_W = 16;
	localparam int VERDICT_W     = 2;
	localparam int CFG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 48;

	localparam logic [TIME_W-1:0]        RST_STARTUP_RELEASE = '0;
	localparam logic [INTERVAL_W-1:0]    RST_MIN_INTERVAL    = 32'd10000000;
	localparam logic [PERIOD_W-1:0]      RST_CREDIT_PERIOD   = 32'd8000000;
	localparam logic [INIT_CREDIT_W-1:0] RST_INITIAL_CREDIT  = 16'd5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_STARTUP_RELEASE = 2'd0,
		CFG_MIN_INTERVAL    = 2'd1,
		CFG_CREDIT_PERIOD   = 2'd2,
		CFG_INITIAL_CREDIT  = 2'd3
	} cfg_reg_t;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_SPOKEN        = 2'd0,
		VERDICT_MUTED_STARTUP = 2'd1,
		VERDICT_MUTED_RATE    = 2'd2,
		VERDICT_MUTED_CREDIT  = 2'd3
	} verdict_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_LOAD,
		S_CHECK,
		S_ROUTE,
		S_SAT,
		S_DIV,
		S_ADD,
		S_DECIDE,
		S_COMMIT
	} state_t;

	typedef struct packed {
		logic [CREDIT_W-1:0] credit;
		logic [TIME_W-1:0]   refill;
		logic [TIME_W-1:0]   speak;
	} entry_t;

	typedef struct packed {
		logic clr_step;
		logic accept;
		logic load;
		logic check;
		logic mute_startup;
		logic mute_rate;
		logic touch_refill;
		logic sat;
		logic add;
		logic decide;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic startup_mute;
		logic rate_mute;
		logic credit_low;
		logic refill_set;
		logic div_done;
		logic out_free;
	} sts_t;

	typedef logic [TOPIC_SPAN-1:0][TOPIC_TBL_W-1:0] topic_tbl_t;

	// topic index reduced modulo the topic count, for every input code
	function automatic topic_tbl_t topic_mod_table(input int count);
		topic_tbl_t tbl;
		int         cnt;
		cnt = 0;
		for (int i = 0; i < TOPIC_SPAN; i++) begin
			tbl[i] = TOPIC_TBL_W'(cnt);
			cnt    = (cnt == count - 1) ? 0 : cnt + 1;
		end
		return tbl;
	endfunction

endpackage

// ----- sv/ptarl_if.sv -----
// Request and result channel interfaces of the alarm rate limiter.
// Depends on ptarl_pkg for field widths.
interface ptarl_req_if;
	logic                          valid;
	logic                          ready;
	logic [ptarl_pkg::TOPIC_W-1:0] topic_index;
	logic [ptarl_pkg::TIME_W-1:0]  now_time;

	modport source (output valid, output topic_index, output now_time, input ready);
	modport sink   (input valid, input topic_index, input now_time, output ready);
endinterface

interface ptarl_res_if;
	logic                            valid;
	logic                            ready;
	logic [ptarl_pkg::VERDICT_W-1:0] verdict;
	logic [ptarl_pkg::CREDIT_W-1:0]  credit_left;

	modport source (output valid, output verdict, output credit_left, input ready);
	modport sink   (input valid, input verdict, input credit_left, output ready);
endinterface

// ----- sv/ptarl_div.sv -----
// Restoring divider, one quotient bit per cycle, 32-bit quotient and divisor.
// Depends on ptarl_pkg; used by ptarl_dp for the credit refill.
module ptarl_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ptarl_pkg::CREDIT_W-1:0] rem_init,
	input  logic [ptarl_pkg::CREDIT_W-1:0] num_low,
	input  logic [ptarl_pkg::CREDIT_W-1:0] divisor,
	output logic [ptarl_pkg::CREDIT_W-1:0] quot,
	output logic                           done
);
	localparam int CW    = ptarl_pkg::CREDIT_W;
	localparam int CNT_W = $clog2(CW);

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    sh_q;
	logic [CW-1:0]    div_q;
	logic [CW+1:0]    trial;
	logic             q_bit;
	logic [CW-1:0]    rem_next;

	// rem_q stays below div_q, so the shifted trial value fits 33 bits
	assign trial    = {1'b0, rem_q, sh_q[CW-1]} - {2'b00, div_q};
	assign q_bit    = ~trial[CW+1];
	assign rem_next = q_bit ? trial[CW-1:0] : {rem_q[CW-2:0], sh_q[CW-1]};
	assign quot     = sh_q;
	assign done     = busy_q && (cnt_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(CW - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			sh_q  <= num_low;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_next;
			sh_q  <= {sh_q[CW-2:0], q_bit};
		end
	end

endmodule

// ----- sv/ptarl_dp.sv -----
// Datapath: config registers, per-topic tables, credit arithmetic and result register.
// Depends on ptarl_pkg; instantiates ptarl_div; driven by ptarl_ctrl commands.
module ptarl_dp #(
	parameter int TOPIC_COUNT          = ptarl_pkg::TOPIC_COUNT_DEF,
	parameter int CREDIT_FRACTION_BITS = ptarl_pkg::CREDIT_FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ptarl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ptarl_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic [ptarl_pkg::TOPIC_W-1:0]     in_topic,
	input  logic [ptarl_pkg::TIME_W-1:0]      in_now,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [ptarl_pkg::VERDICT_W-1:0]   out_verdict,
	output logic [ptarl_pkg::CREDIT_W-1:0]    out_credit,
	input  ptarl_pkg::cmd_t                   cmd,
	output ptarl_pkg::sts_t                   sts
);
	localparam int TIW     = (TOPIC_COUNT > 1) ? $clog2(TOPIC_COUNT) : 1;
	localparam int CW      = ptarl_pkg::CREDIT_W;
	localparam int TW      = ptarl_pkg::TIME_W;
	localparam int IW      = ptarl_pkg::INIT_CREDIT_W;
	localparam int F       = CREDIT_FRACTION_BITS;
	localparam int INIT_WW = IW + F;
	localparam int BOUND_W = 2 * CW;
	localparam int NUM_W   = TW + F;
	localparam logic [CW-1:0] CREDIT_ONE = {{(CW-1){1'b0}}, 1'b1} << F;
	localparam ptarl_pkg::topic_tbl_t TOPIC_TBL = ptarl_pkg::topic_mod_table(TOPIC_COUNT);

	// configuration
	logic [TW-1:0]                           srt_q;
	logic [ptarl_pkg::INTERVAL_W-1:0]        min_q;
	logic [ptarl_pkg::PERIOD_W-1:0]          period_q;
	logic [IW-1:0]                           init_q;

	// tables
	logic                                    seen_mem [TOPIC_COUNT];
	ptarl_pkg::entry_t                       ent_mem  [TOPIC_COUNT];
	logic                                    seen_rd_q;
	ptarl_pkg::entry_t                       ent_rd_q;
	logic [TIW-1:0]                          clr_q;
	logic [TIW-1:0]                          in_addr;

	// working registers
	logic [TIW-1:0]                          topic_q;
	logic [TW-1:0]                           now_q;
	logic [CW-1:0]                           credit_q;
	logic [TW-1:0]                           refill_q;
	logic [TW-1:0]                           speak_q;
	logic [TW-1:0]                           elapsed_q;
	logic                                    startup_q;
	logic                                    rate_q;
	logic                                    credit_low_q;
	logic                                    refill_set_q;
	logic                                    amt_sat_q;
	ptarl_pkg::verdict_t                     verdict_q;
	logic                                    out_valid_q;
	logic [ptarl_pkg::VERDICT_W-1:0]         out_verdict_q;
	logic [CW-1:0]                           out_credit_q;

	logic [INIT_WW-1:0]                      init_wide;
	logic [CW-1:0]                           init_credit;
	logic [TW:0]                             speak_diff;
	logic [TW:0]                             refill_diff;
	logic [CW-1:0]                           period_eff;
	logic [BOUND_W-1:0]                      sat_bound;
	logic [NUM_W-1:0]                        div_num;
	logic [CW-1:0]                           div_quot;
	logic                                    div_done;
	logic [CW-1:0]                           amt;
	logic [CW:0]                             credit_sum;
	ptarl_pkg::entry_t                       ent_wr;

	assign in_addr     = TOPIC_TBL[in_topic][TIW-1:0];
	assign init_wide   = {init_q, {F{1'b0}}};
	assign init_credit = (|(init_wide >> CW)) ? '1 : CW'(init_wide);
	assign speak_diff  = {1'b0, now_q} - {1'b0, speak_q};
	assign refill_diff = {1'b0, now_q} - {1'b0, refill_q};
	assign period_eff  = (period_q == '0) ? {{(CW-1){1'b0}}, 1'b1} : period_q;
	assign sat_bound   = {{CW{1'b0}}, period_eff} << (CW - F);
	assign div_num     = {elapsed_q, {F{1'b0}}};
	assign amt         = amt_sat_q ? '1 : div_quot;
	assign credit_sum  = {1'b0, credit_q} + {1'b0, amt};
	assign ent_wr      = '{credit: credit_q, refill: refill_q, speak: speak_q};

	ptarl_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sat),
		.rem_init (CW'(div_num >> CW)),
		.num_low  (div_num[CW-1:0]),
		.divisor  (period_eff),
		.quot     (div_quot),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srt_q    <= ptarl_pkg::RST_STARTUP_RELEASE;
			min_q    <= ptarl_pkg::RST_MIN_INTERVAL;
			period_q <= ptarl_pkg::RST_CREDIT_PERIOD;
			init_q   <= ptarl_pkg::RST_INITIAL_CREDIT;
		end else if (cfg_we) begin
			case (ptarl_pkg::cfg_reg_t'(cfg_index))
				ptarl_pkg::CFG_STARTUP_RELEASE: srt_q    <= cfg_data[TW-1:0];
				ptarl_pkg::CFG_MIN_INTERVAL:    min_q    <= cfg_data[ptarl_pkg::INTERVAL_W-1:0];
				ptarl_pkg::CFG_CREDIT_PERIOD:   period_q <= cfg_data[ptarl_pkg::PERIOD_W-1:0];
				ptarl_pkg::CFG_INITIAL_CREDIT:  init_q   <= cfg_data[IW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			seen_mem[clr_q] <= 1'b0;
		end else if (cmd.commit) begin
			seen_mem[topic_q] <= 1'b1;
		end
		if (cmd.commit) begin
			ent_mem[topic_q] <= ent_wr;
		end
		if (cmd.accept) begin
			seen_rd_q <= seen_mem[in_addr];
			ent_rd_q  <= ent_mem[in_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			topic_q <= in_addr;
			now_q   <= in_now;
		end
		if (cmd.load) begin
			credit_q  <= seen_rd_q ? ent_rd_q.credit : init_credit;
			refill_q  <= seen_rd_q ? ent_rd_q.refill : '0;
			speak_q   <= seen_rd_q ? ent_rd_q.speak : '0;
			startup_q <= now_q < srt_q;
		end
		if (cmd.check) begin
			rate_q       <= speak_diff[TW] || (speak_diff[TW-1:0] < TW'(min_q));
			elapsed_q    <= refill_diff[TW] ? '0 : refill_diff[TW-1:0];
			credit_low_q <= credit_q < CREDIT_ONE;
			refill_set_q <= refill_q != '0;
		end
		if (cmd.mute_startup) begin
			verdict_q <= ptarl_pkg::VERDICT_MUTED_STARTUP;
		end
		if (cmd.mute_rate) begin
			verdict_q <= ptarl_pkg::VERDICT_MUTED_RATE;
		end
		if (cmd.touch_refill) begin
			refill_q <= now_q;
		end
		if (cmd.sat) begin
			amt_sat_q <= BOUND_W'(elapsed_q) >= sat_bound;
		end
		if (cmd.add) begin
			credit_q <= credit_sum[CW] ? '1 : credit_sum[CW-1:0];
			refill_q <= now_q;
		end
		if (cmd.decide) begin
			if (credit_q < CREDIT_ONE) begin
				verdict_q <= ptarl_pkg::VERDICT_MUTED_CREDIT;
			end else begin
				credit_q  <= credit_q - CREDIT_ONE;
				speak_q   <= now_q;
				verdict_q <= ptarl_pkg::VERDICT_SPOKEN;
			end
		end
		if (cmd.commit) begin
			out_verdict_q <= verdict_q;
			out_credit_q  <= credit_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_verdict = out_verdict_q;
	assign out_credit  = out_credit_q;

	assign sts.clr_last     = clr_q == TIW'(TOPIC_COUNT - 1);
	assign sts.startup_mute = startup_q;
	assign sts.rate_mute    = rate_q;
	assign sts.credit_low   = credit_low_q;
	assign sts.refill_set   = refill_set_q;
	assign sts.div_done     = div_done;
	assign sts.out_free     = !out_valid_q || out_ready;

endmodule

// ----- sv/ptarl_ctrl.sv -----
// Controller state machine: table clear after reset, then one request at a time.
// Depends on ptarl_pkg; issues commands to ptarl_dp and reads its status.
module ptarl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output ptarl_pkg::cmd_t cmd,
	input  ptarl_pkg::sts_t sts
);
	ptarl_pkg::state_t state_q;
	ptarl_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ptarl_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptarl_pkg::S_CLEAR: begin
				if (sts.clr_last) state_d = ptarl_pkg::S_IDLE;
			end
			ptarl_pkg::S_IDLE: begin
				if (in_valid) state_d = ptarl_pkg::S_LOAD;
			end
			ptarl_pkg::S_LOAD:  state_d = ptarl_pkg::S_CHECK;
			ptarl_pkg::S_CHECK: state_d = ptarl_pkg::S_ROUTE;
			ptarl_pkg::S_ROUTE: begin
				if (sts.startup_mute || sts.rate_mute) begin
					state_d = ptarl_pkg::S_COMMIT;
				end else if (sts.credit_low && sts.refill_set) begin
					state_d = ptarl_pkg::S_SAT;
				end else begin
					state_d = ptarl_pkg::S_DECIDE;
				end
			end
			ptarl_pkg::S_SAT: state_d = ptarl_pkg::S_DIV;
			ptarl_pkg::S_DIV: begin
				if (sts.div_done) state_d = ptarl_pkg::S_ADD;
			end
			ptarl_pkg::S_ADD:    state_d = ptarl_pkg::S_DECIDE;
			ptarl_pkg::S_DECIDE: state_d = ptarl_pkg::S_COMMIT;
			ptarl_pkg::S_COMMIT: begin
				if (sts.out_free) state_d = ptarl_pkg::S_IDLE;
			end
			default: state_d = ptarl_pkg::S_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ptarl_pkg::S_CLEAR: cmd.clr_step = 1'b1;
			ptarl_pkg::S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ptarl_pkg::S_LOAD:  cmd.load = 1'b1;
			ptarl_pkg::S_CHECK: cmd.check = 1'b1;
			ptarl_pkg::S_ROUTE: begin
				if (sts.startup_mute) begin
					cmd.mute_startup = 1'b1;
				end else if (sts.rate_mute) begin
					cmd.mute_rate = 1'b1;
				end else if (sts.credit_low && !sts.refill_set) begin
					cmd.touch_refill = 1'b1;
				end
			end
			ptarl_pkg::S_SAT:    cmd.sat = 1'b1;
			ptarl_pkg::S_DIV:    ;
			ptarl_pkg::S_ADD:    cmd.add = 1'b1;
			ptarl_pkg::S_DECIDE: cmd.decide = 1'b1;
			ptarl_pkg::S_COMMIT: cmd.commit = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ----- sv/per_topic_alarm_rate_limiter_core.sv -----
// Per-topic alarm rate limiter (token bucket per topic), top level.
// Depends on ptarl_pkg, ptarl_if, ptarl_ctrl, ptarl_dp and ptarl_div.
//
// req carries one alarm request word (topic_index, now_time); res returns one
// word per request (verdict, credit_left). Both use valid/ready.
// The cfg port writes the four registers by index; the user writes them only
// while the block is idle, and the block itself does not enforce it.
// After reset the topic table is swept clear, one topic per cycle, and
// req.ready stays low until the sweep is done. One request is worked at a
// time. From acceptance to res.valid it passes S_LOAD, S_CHECK and S_ROUTE;
// a mute at startup or by interval then goes straight to S_COMMIT, a credit
// check without refill through S_DECIDE, and a credit refill through S_SAT,
// S_DIV (the serial divider) and S_ADD before S_DECIDE. ready returns in
// the cycle after the result is loaded; the divider sets the longest path.
// The result sits in an output register: if res.ready is low the next
// request is still accepted and worked, and waits only to load its result.
module per_topic_alarm_rate_limiter_core #(
	parameter int TOPIC_COUNT          = ptarl_pkg::TOPIC_COUNT_DEF,
	parameter int CREDIT_FRACTION_BITS = ptarl_pkg::CREDIT_FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	ptarl_req_if.sink                         req,
	ptarl_res_if.source                       res,
	input  logic                              cfg_we,
	input  logic [ptarl_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [ptarl_pkg::CFG_DATA_W-1:0]  cfg_data
);
	ptarl_pkg::cmd_t cmd;
	ptarl_pkg::sts_t sts;

	ptarl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	ptarl_dp #(
		.TOPIC_COUNT          (TOPIC_COUNT),
		.CREDIT_FRACTION_BITS (CREDIT_FRACTION_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_topic    (req.topic_index),
		.in_now      (req.now_time),
		.out_ready   (res.ready),
		.out_valid   (res.valid),
		.out_verdict (res.verdict),
		.out_credit  (res.credit_left),
		.cmd         (cmd),
		.sts         (sts)
	);

`ifndef NO_ASSERTIONS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request accepted while another is in work");

	a_commit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!res.valid || res.ready))
		else $error("result overwrites a word not yet taken");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> res.valid)
		else $error("committed result not presented");
`endif

endmodule
